// File: hdl/msr_pkg.sv
// Shared types and constants for the motor speed step regulator.
// Holds command codes, register indexes, reset values and the configuration struct.
// No dependencies.
package msr_pkg;

    localparam int CMD_W     = 3;
    localparam int SAMPLE_W  = 10;
    localparam int DRIVE_W   = 8;
    localparam int COUNT_W   = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADJUST = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PULSE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd3;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 10'd512;
    localparam logic [COUNT_W-1:0]  WINDOW_RST    = 16'd1000;
    localparam logic [COUNT_W-1:0]  TARGET_RST    = 16'd0;
    localparam logic [DRIVE_W-1:0]  STEP_RST      = 8'd1;

    // One bit wider than the drive so that the headroom subtraction cannot wrap.
    localparam logic [DRIVE_W:0] DRIVE_MAX = 9'd255;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sensor_threshold;
        logic [COUNT_W-1:0]  window_ms;
        logic [COUNT_W-1:0]  target_rate;
        logic [DRIVE_W-1:0]  drive_step;
    } cfg_t;

endpackage

// File: hdl/motor_speed_step_regulator_core.sv
// Top level of the motor speed step regulator: input register, regulator datapath
// and result register. Depends on msr_pkg, msr_cfg_regs and msr_datapath.
//
// The regulator takes one command transaction per clock cycle while the output is not
// stalled and returns exactly one result per command, passing it through the input
// register and then the result register. Between the two, all the state update
// (sample compare, tick compare and deadline add, drive step) happens in a single pass;
// the state seen by a command includes every earlier command. When the output is
// stalled the input register still takes one more transaction before the input stalls.
// Configuration writes are always ready and take effect on the next cycle; they should
// only be issued while no command is in flight.
module motor_speed_step_regulator_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [msr_pkg::CMD_W-1:0]      command,
    input  logic [msr_pkg::SAMPLE_W-1:0]   sample_value,
    input  logic [msr_pkg::DRIVE_W-1:0]    drive_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [msr_pkg::DRIVE_W-1:0]    drive_level,
    output logic [msr_pkg::COUNT_W-1:0]    measured_rate,
    output logic [msr_pkg::COUNT_W-1:0]    revolution_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [msr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msr_pkg::CFG_DAT_W-1:0]  cfg_data
);

    msr_pkg::cfg_t cfg;

    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic [msr_pkg::CMD_W-1:0]    command_reg;
    logic [msr_pkg::SAMPLE_W-1:0] sample_reg;
    logic [msr_pkg::DRIVE_W-1:0]  drive_value_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [msr_pkg::DRIVE_W-1:0]  drive_level_reg;
    logic [msr_pkg::COUNT_W-1:0]  rate_out_reg;
    logic [msr_pkg::COUNT_W-1:0]  revs_out_reg;
    logic [msr_pkg::DRIVE_W-1:0]  drive_next;
    logic [msr_pkg::COUNT_W-1:0]  rate_next;
    logic [msr_pkg::COUNT_W-1:0]  revs_next;
    logic                         out_free;
    logic                         fire;
    logic                         in_take;

    assign cfg_ready = 1'b1;

    // The result register is free when empty or when its transaction leaves this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign in_valid_next  = in_take || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && out_stall);

    msr_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    msr_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .command      (command_reg),
        .sample_value (sample_reg),
        .drive_value  (drive_value_reg),
        .cfg          (cfg),
        .drive_next   (drive_next),
        .rate_next    (rate_next),
        .revs_next    (revs_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            command_reg     <= command;
            sample_reg      <= sample_value;
            drive_value_reg <= drive_value;
        end
        if (fire)
        begin
            drive_level_reg <= drive_next;
            rate_out_reg    <= rate_next;
            revs_out_reg    <= revs_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign drive_level      = drive_level_reg;
    assign measured_rate    = rate_out_reg;
    assign revolution_count = revs_out_reg;

    // The input only stalls when both registers hold a transaction and the output is blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && in_valid_reg))
        else $error("input stalled while the result register could drain");

    // A processed command always produces a result in the next cycle.
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed command produced no result");

endmodule

// File: hdl/msr_cfg_regs.sv
// Configuration register bank of the motor speed step regulator.
// Depends on msr_pkg for the register indexes, reset values and cfg_t.
module msr_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [msr_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [msr_pkg::CFG_DAT_W-1:0]  wr_data,
    output msr_pkg::cfg_t                  cfg
);

    msr_pkg::cfg_t cfg_reg;
    msr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                msr_pkg::REG_THRESHOLD:
                    cfg_next.sensor_threshold = wr_data[msr_pkg::SAMPLE_W-1:0];
                msr_pkg::REG_WINDOW:
                    cfg_next.window_ms = wr_data[msr_pkg::COUNT_W-1:0];
                msr_pkg::REG_TARGET:
                    cfg_next.target_rate = wr_data[msr_pkg::COUNT_W-1:0];
                msr_pkg::REG_STEP:
                    cfg_next.drive_step = wr_data[msr_pkg::DRIVE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_threshold <= msr_pkg::THRESHOLD_RST;
            cfg_reg.window_ms        <= msr_pkg::WINDOW_RST;
            cfg_reg.target_rate      <= msr_pkg::TARGET_RST;
            cfg_reg.drive_step       <= msr_pkg::STEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/msr_datapath.sv
// Regulator state and the single-pass update for one command.
// Depends on msr_pkg for command codes, widths and cfg_t.
module msr_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [msr_pkg::CMD_W-1:0]     command,
    input  logic [msr_pkg::SAMPLE_W-1:0]  sample_value,
    input  logic [msr_pkg::DRIVE_W-1:0]   drive_value,
    input  msr_pkg::cfg_t                 cfg,
    output logic [msr_pkg::DRIVE_W-1:0]   drive_next,
    output logic [msr_pkg::COUNT_W-1:0]   rate_next,
    output logic [msr_pkg::COUNT_W-1:0]   revs_next
);

    logic [msr_pkg::DRIVE_W-1:0] drive_reg;
    logic                        mark_reg;
    logic                        mark_next;
    logic [msr_pkg::COUNT_W-1:0] revs_reg;
    logic [msr_pkg::COUNT_W-1:0] revs_win_reg;
    logic [msr_pkg::COUNT_W-1:0] revs_win_next;
    logic [msr_pkg::COUNT_W-1:0] rate_reg;
    logic [msr_pkg::TIME_W-1:0]  time_reg;
    logic [msr_pkg::TIME_W-1:0]  time_next;
    logic [msr_pkg::TIME_W-1:0]  deadline_reg;
    logic [msr_pkg::TIME_W-1:0]  deadline_next;
    logic [msr_pkg::TIME_W-1:0]  time_inc;
    logic [msr_pkg::DRIVE_W:0]   headroom;

    assign time_inc = time_reg + 32'd1;
    assign headroom = msr_pkg::DRIVE_MAX - {1'b0, cfg.drive_step};

    always_comb
    begin
        drive_next    = drive_reg;
        mark_next     = mark_reg;
        revs_next     = revs_reg;
        revs_win_next = revs_win_reg;
        rate_next     = rate_reg;
        time_next     = time_reg;
        deadline_next = deadline_reg;
        if (fire)
        begin
            unique case (command)
                msr_pkg::CMD_SAMPLE:
                begin
                    // Only the rising edge of the mark counts a revolution.
                    if (sample_value > cfg.sensor_threshold)
                    begin
                        if (!mark_reg)
                        begin
                            revs_next = revs_reg + 16'd1;
                        end
                        mark_next = 1'b1;
                    end
                    else
                    begin
                        mark_next = 1'b0;
                    end
                end
                msr_pkg::CMD_TICK:
                begin
                    time_next = time_inc;
                    if (time_inc > deadline_reg)
                    begin
                        deadline_next = time_inc + {16'd0, cfg.window_ms};
                        rate_next     = revs_reg - revs_win_reg;
                        revs_win_next = revs_reg;
                    end
                end
                msr_pkg::CMD_ADJUST:
                begin
                    if (rate_reg < cfg.target_rate)
                    begin
                        if ({1'b0, drive_reg} < headroom)
                        begin
                            drive_next = drive_reg + cfg.drive_step;
                        end
                    end
                    else if (rate_reg > cfg.target_rate)
                    begin
                        if (drive_reg >= cfg.drive_step)
                        begin
                            drive_next = drive_reg - cfg.drive_step;
                        end
                        else
                        begin
                            drive_next = '0;
                        end
                    end
                end
                msr_pkg::CMD_PULSE:
                begin
                    revs_next = revs_reg + 16'd1;
                end
                msr_pkg::CMD_LOAD:
                begin
                    drive_next = drive_value;
                end
                default:
                begin
                    drive_next = drive_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg    <= '0;
            mark_reg     <= 1'b0;
            revs_reg     <= '0;
            revs_win_reg <= '0;
            rate_reg     <= '0;
            time_reg     <= '0;
            deadline_reg <= '0;
        end
        else
        begin
            drive_reg    <= drive_next;
            mark_reg     <= mark_next;
            revs_reg     <= revs_next;
            revs_win_reg <= revs_win_next;
            rate_reg     <= rate_next;
            time_reg     <= time_next;
            deadline_reg <= deadline_next;
        end
    end

    // The measured rate only moves when a tick transaction is processed.
    a_rate_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && command == msr_pkg::CMD_TICK) |=> $stable(rate_reg))
        else $error("measured rate changed without a tick");

    // At most one revolution is counted per processed transaction.
    a_revs_single_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (revs_reg == $past(revs_reg)) || (revs_reg == $past(revs_reg) + 16'd1))
        else $error("revolution count jumped by more than one");

    // The deadline is only ever moved on a millisecond tick, together with the time.
    a_deadline_with_time: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(deadline_reg) |-> (time_reg == $past(time_reg) + 32'd1))
        else $error("deadline moved without the time advancing");

endmodule

// File: verif/tb.sv
// Self-checking testbench for motor_speed_step_regulator_core: directed and random
// command traffic, register writes between phases and an on-the-fly result check.
// Depends on msr_pkg and the regulator RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msr_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int IDLE_PERCENT  = 13;
    localparam int DRAIN_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int MAX_REPORTS   = 100;
    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_ITEMS   = 160;

    localparam logic [CMD_W-1:0]     CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0]     CMD_SPARE_LAST  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive_level;
        logic [COUNT_W-1:0] measured_rate;
        logic [COUNT_W-1:0] revolution_count;
    } speed_report_t;

    logic                 clk              = 1'b0;
    logic                 rst_n            = 1'b0;
    logic                 in_valid         = 1'b0;
    logic                 in_stall;
    logic [CMD_W-1:0]     command          = '0;
    logic [SAMPLE_W-1:0]  sample_value     = '0;
    logic [DRIVE_W-1:0]   drive_value      = '0;
    logic                 out_valid;
    logic                 out_stall        = 1'b0;
    logic [DRIVE_W-1:0]   drive_level;
    logic [COUNT_W-1:0]   measured_rate;
    logic [COUNT_W-1:0]   revolution_count;
    logic                 cfg_valid        = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index        = '0;
    logic [CFG_DAT_W-1:0] cfg_data         = '0;

    // Settings and state of the regulator as this bench predicts them.
    logic [SAMPLE_W-1:0] thr_setting    = THRESHOLD_RST;
    logic [COUNT_W-1:0]  window_setting = WINDOW_RST;
    logic [COUNT_W-1:0]  target_setting = TARGET_RST;
    logic [DRIVE_W-1:0]  step_setting   = STEP_RST;
    logic [DRIVE_W-1:0]  drive_now      = '0;
    logic                mark_seen      = 1'b0;
    logic [COUNT_W-1:0]  rev_total      = '0;
    logic [COUNT_W-1:0]  rev_at_close   = '0;
    logic [COUNT_W-1:0]  rate_now       = '0;
    logic [TIME_W-1:0]   ms_now         = '0;
    logic [TIME_W-1:0]   deadline_now   = '0;

    speed_report_t pending_reports[$];
    int unsigned   fail_count   = 0;
    int unsigned   cycle_count  = 0;
    bit            idle_enabled = 1'b1;

    motor_speed_step_regulator_core i_dut (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= idle_enabled && ($urandom_range(99) < IDLE_PERCENT);
    end

    function automatic logic [SAMPLE_W-1:0] any_sample();
        return SAMPLE_W'($urandom());
    endfunction

    function automatic logic [DRIVE_W-1:0] any_drive();
        return DRIVE_W'($urandom());
    endfunction

    function automatic speed_report_t predict_report(input logic [CMD_W-1:0]    cmd,
                                                      input logic [SAMPLE_W-1:0] smp,
                                                      input logic [DRIVE_W-1:0]  dv);
        speed_report_t rep;
        case (cmd)
            CMD_SAMPLE:
            begin
                if (smp > thr_setting)
                begin
                    if (!mark_seen)
                        rev_total = rev_total + 1'b1;
                    mark_seen = 1'b1;
                end
                else
                    mark_seen = 1'b0;
            end
            CMD_TICK:
            begin
                ms_now = ms_now + 1'b1;
                if (ms_now > deadline_now)
                begin
                    deadline_now = ms_now + window_setting;
                    rate_now     = rev_total - rev_at_close;
                    rev_at_close = rev_total;
                end
            end
            CMD_ADJUST:
            begin
                if (rate_now < target_setting)
                begin
                    if (int'(drive_now) < int'(DRIVE_MAX) - int'(step_setting))
                        drive_now = drive_now + step_setting;
                end
                else if (rate_now > target_setting)
                    drive_now = (drive_now >= step_setting) ? drive_now - step_setting : '0;
            end
            CMD_PULSE:
                rev_total = rev_total + 1'b1;
            CMD_LOAD:
                drive_now = dv;
            default:
                ;
        endcase
        rep.drive_level      = drive_now;
        rep.measured_rate    = rate_now;
        rep.revolution_count = rev_total;
        return rep;
    endfunction

    function automatic void note_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
    endfunction

    always @(posedge clk)
    begin
        speed_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $error("result transaction with no command outstanding");
            end
            else
            begin
                want = pending_reports.pop_front();
                if (drive_level !== want.drive_level)
                    note_mismatch("drive_level", 32'(want.drive_level), 32'(drive_level));
                if (measured_rate !== want.measured_rate)
                    note_mismatch("measured_rate", 32'(want.measured_rate),
                                  32'(measured_rate));
                if (revolution_count !== want.revolution_count)
                    note_mismatch("revolution_count", 32'(want.revolution_count),
                                  32'(revolution_count));
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance with the
    // valid left high, so that back-to-back transactions never toggle it within a step.
    task automatic send_command(input logic [CMD_W-1:0]    cmd,
                                input logic [SAMPLE_W-1:0] smp,
                                input logic [DRIVE_W-1:0]  dv);
        while (idle_enabled && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        sample_value <= smp;
        drive_value  <= dv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_reports.push_back(predict_report(cmd, smp, dv));
        @(negedge clk);
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_THRESHOLD: thr_setting    = data[SAMPLE_W-1:0];
            REG_WINDOW:    window_setting = data[COUNT_W-1:0];
            REG_TARGET:    target_setting = data[COUNT_W-1:0];
            REG_STEP:      step_setting   = data[DRIVE_W-1:0];
            default:       ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DAT_W-1:0] thr_data,
                                  input logic [CFG_DAT_W-1:0] win_data,
                                  input logic [CFG_DAT_W-1:0] tgt_data,
                                  input logic [CFG_DAT_W-1:0] step_data);
        wait_until_drained();
        write_register(REG_THRESHOLD, thr_data);
        write_register(REG_WINDOW, win_data);
        write_register(REG_TARGET, tgt_data);
        write_register(REG_STEP, step_data);
        // Writes past the last register must leave everything untouched.
        write_register(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                       CFG_DAT_W'($urandom()));
    endtask

    task automatic send_random_command();
        int                  pick;
        logic [CMD_W-1:0]    cmd;
        logic [SAMPLE_W-1:0] smp;
        logic [DRIVE_W-1:0]  dv;
        pick = $urandom_range(99);
        smp  = any_sample();
        dv   = any_drive();
        if (pick < 40)
        begin
            cmd = CMD_SAMPLE;
            // Most samples alternate around the threshold so that marks come and go.
            if (pick < 36)
            begin
                if (!mark_seen && thr_setting != '1)
                    smp = SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1,
                                                   int'(thr_setting) + 1));
                else
                    smp = SAMPLE_W'($urandom_range(int'(thr_setting), 0));
            end
        end
        else if (pick < 55)
            cmd = CMD_PULSE;
        else if (pick < 75)
            cmd = CMD_TICK;
        else if (pick < 90)
            cmd = CMD_ADJUST;
        else if (pick < 97)
            cmd = CMD_LOAD;
        else
            cmd = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        send_command(cmd, smp, dv);
    endtask

    task automatic test_sensor_threshold();
        send_command(CMD_SAMPLE, '0, '0);
        send_command(CMD_SAMPLE, '1, '1);
        // The mark is still present, so this one must not count again.
        send_command(CMD_SAMPLE, THRESHOLD_RST + 1'b1, any_drive());
        send_command(CMD_SAMPLE, THRESHOLD_RST, any_drive());
        send_command(CMD_SAMPLE, THRESHOLD_RST + 1'b1, any_drive());
        for (int c = int'(CMD_SPARE_FIRST); c <= int'(CMD_SPARE_LAST); c++)
            send_command(c[CMD_W-1:0], any_sample(), any_drive());
        wait_until_drained();
        write_register(REG_THRESHOLD, '1);
        send_command(CMD_SAMPLE, '1, any_drive());
        wait_until_drained();
        write_register(REG_THRESHOLD, '0);
        send_command(CMD_SAMPLE, '0, any_drive());
        send_command(CMD_SAMPLE, 10'd1, any_drive());
    endtask

    task automatic test_window_close();
        wait_until_drained();
        write_register(REG_WINDOW, '0);
        send_command(CMD_PULSE, any_sample(), any_drive());
        send_command(CMD_PULSE, any_sample(), any_drive());
        send_command(CMD_TICK, any_sample(), any_drive());
        send_command(CMD_PULSE, any_sample(), any_drive());
        send_command(CMD_TICK, any_sample(), any_drive());
        send_command(CMD_TICK, any_sample(), any_drive());
    endtask

    task automatic test_drive_adjust();
        send_command(CMD_ADJUST, any_sample(), any_drive());
        send_command(CMD_PULSE, any_sample(), any_drive());
        send_command(CMD_TICK, any_sample(), any_drive());
        send_command(CMD_LOAD, any_sample(), '1);
        send_command(CMD_ADJUST, any_sample(), any_drive());
        wait_until_drained();
        write_register(REG_STEP, '1);
        // A step larger than the drive must stop at zero.
        send_command(CMD_ADJUST, any_sample(), any_drive());
        wait_until_drained();
        write_register(REG_TARGET, '1);
        write_register(REG_STEP, 16'd5);
        send_command(CMD_LOAD, any_sample(), 8'd249);
        send_command(CMD_ADJUST, any_sample(), any_drive());
        send_command(CMD_ADJUST, any_sample(), any_drive());
        send_command(CMD_LOAD, any_sample(), '0);
        wait_until_drained();
        write_register(REG_STEP, 16'h00FF);
        send_command(CMD_ADJUST, any_sample(), any_drive());
        wait_until_drained();
        write_register(REG_TARGET, 16'd1);
        send_command(CMD_ADJUST, any_sample(), any_drive());
    endtask

    task automatic test_random_traffic();
        logic [CFG_DAT_W-1:0] thr_data;
        logic [CFG_DAT_W-1:0] win_data;
        logic [CFG_DAT_W-1:0] tgt_data;
        logic [CFG_DAT_W-1:0] step_data;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                thr_data  = '0;
                win_data  = '0;
                tgt_data  = '0;
                step_data = '0;
            end
            else
            begin
                thr_data  = CFG_DAT_W'($urandom_range(1) ? $urandom() : $urandom_range(1023));
                win_data  = CFG_DAT_W'($urandom_range(12));
                tgt_data  = CFG_DAT_W'($urandom_range(12));
                step_data = CFG_DAT_W'($urandom_range(1) ? $urandom_range(255)
                                                         : $urandom_range(8));
            end
            apply_settings(thr_data, win_data, tgt_data, step_data);
            // Two phases run with neither side ever holding off.
            idle_enabled = !(phase == 4 || phase == 5);
            repeat (PHASE_ITEMS) send_random_command();
        end
        idle_enabled = 1'b1;
    endtask

    task automatic test_extreme_settings();
        apply_settings('1, '1, '1, '1);
        repeat (PHASE_ITEMS) send_random_command();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_sensor_threshold();
        test_window_close();
        test_drive_adjust();
        test_random_traffic();
        test_extreme_settings();
        wait_until_drained();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
